// ----- rtl/i2crts_pkg.sv -----
// Shared types and constants of the I2C master register transfer sequencer.
`default_nettype none

package i2crts_pkg;

    // Item kinds on the input channel.
    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_START  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // Controller status codes that the sequencer acts upon.
    localparam logic [7:0] ST_START_SENT   = 8'h08;
    localparam logic [7:0] ST_RESTART_SENT = 8'h10;
    localparam logic [7:0] ST_ADDR_W_ACK   = 8'h18;
    localparam logic [7:0] ST_DATA_W_ACK   = 8'h28;
    localparam logic [7:0] ST_ARB_LOST     = 8'h38;
    localparam logic [7:0] ST_ADDR_R_ACK   = 8'h40;
    localparam logic [7:0] ST_DATA_R_ACK   = 8'h50;
    localparam logic [7:0] ST_DATA_R_NACK  = 8'h58;

    // Mask that clears the read bit of the device address.
    localparam logic [7:0] ADDR_WRITE_MASK = 8'hFE;

    // Start and acknowledge flag requests.
    localparam logic [1:0] REQ_NONE = 2'd0;
    localparam logic [1:0] REQ_SET  = 2'd1;
    localparam logic [1:0] REQ_CLR  = 2'd2;

    // Completion outcomes.
    localparam logic [1:0] OUTCOME_BUSY       = 2'd0;
    localparam logic [1:0] OUTCOME_WRITE_DONE = 2'd1;
    localparam logic [1:0] OUTCOME_READ_DONE  = 2'd2;

    // Payload of one input transaction.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] buf_index;
        logic [7:0] buf_byte;
        logic [7:0] device_addr;
        logic [7:0] first_reg;
        logic [8:0] length;
        logic [7:0] status_code;
        logic [7:0] rx_data;
    } in_item_t;

    // Payload of one result transaction.
    typedef struct packed {
        logic       load_data;
        logic [7:0] data_out;
        logic [1:0] start_req;
        logic       stop_req;
        logic [1:0] ack_req;
        logic       clear_si;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic [7:0] rx_index;
        logic [1:0] outcome;
        logic [7:0] error_code;
    } out_item_t;

    // Result of the control step, still waiting for the buffer byte if needed.
    typedef struct packed {
        out_item_t res;
        logic      use_mem;
    } step_t;

endpackage

`default_nettype wire

// ----- rtl/i2crts_in_if.sv -----
// Input channel interface of the sequencer.
`default_nettype none

interface i2crts_in_if;
    import i2crts_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/i2crts_out_if.sv -----
// Result channel interface of the sequencer.
`default_nettype none

interface i2crts_out_if;
    import i2crts_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/i2crts_wbuf.sv -----
// Write buffer memory: one write port, one read port with registered data.
`default_nettype none

module i2crts_wbuf #(
    parameter int MAX_LEN = 256,
    parameter int AW      = 8
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [MAX_LEN];
    logic [7:0] rd_data_reg;

    // Synchronous write.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Synchronous read; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/i2crts_ctrl.sv -----
// Transfer state and the per-transaction step decision of the sequencer.
`default_nettype none

module i2crts_ctrl #(
    parameter int MAX_LEN = 256,
    parameter int AW      = 8,
    parameter int BLW     = 9
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 acc,
    input  i2crts_pkg::in_item_t item,
    output i2crts_pkg::step_t    step,
    output logic                 wr_en,
    output logic [AW-1:0]        wr_addr,
    output logic [7:0]           wr_data,
    output logic [AW-1:0]        rd_addr
);
    import i2crts_pkg::*;

    localparam int CW = (BLW > 9) ? BLW : 9;

    logic [7:0]     target_addr_reg, target_addr_next;
    logic [7:0]     start_register_reg, start_register_next;
    logic [BLW-1:0] bytes_left_reg, bytes_left_next;
    logic [AW-1:0]  position_reg, position_next;
    logic [7:0]     error_status_reg, error_status_next;

    logic [AW-1:0]  position_inc;
    logic [BLW-1:0] bytes_dec;
    logic [CW-1:0]  len_ext;
    logic [BLW-1:0] len_sat;
    logic           is_read;
    logic [1:0]     done_outcome;

    // Reduce a buffer index modulo the buffer depth by binary subtraction.
    function automatic logic [AW-1:0] wrap_index(input logic [7:0] idx);
        logic [19:0] v;
        v = 20'(idx);
        for (int k = 7; k >= 0; k--)
        begin
            if (v >= (20'(MAX_LEN) << k))
            begin
                v = v - (20'(MAX_LEN) << k);
            end
        end
        return AW'(v);
    endfunction

    // Helper values shared by several status codes.
    always_comb
    begin
        position_inc = (position_reg == AW'(MAX_LEN - 1)) ? '0 : position_reg + AW'(1);
        bytes_dec    = (bytes_left_reg != '0) ? bytes_left_reg - BLW'(1) : '0;
        len_ext      = CW'(item.length);
        len_sat      = (len_ext > CW'(MAX_LEN)) ? BLW'(MAX_LEN) : BLW'(len_ext);
        is_read      = target_addr_reg[0];
        done_outcome = is_read ? OUTCOME_READ_DONE : OUTCOME_WRITE_DONE;
    end

    // Buffer accesses: loads write at once, every transaction reads at the position.
    assign wr_en   = acc && (item.kind == KIND_LOAD);
    assign wr_addr = wrap_index(item.buf_index);
    assign wr_data = item.buf_byte;
    assign rd_addr = position_reg;

    // Step decision and next transfer state.
    always_comb
    begin
        target_addr_next    = target_addr_reg;
        start_register_next = start_register_reg;
        bytes_left_next     = bytes_left_reg;
        position_next       = position_reg;
        error_status_next   = error_status_reg;
        step                = '0;

        unique case (item.kind)
            KIND_START:
            begin
                target_addr_next    = item.device_addr;
                start_register_next = item.first_reg;
                bytes_left_next     = len_sat;
                position_next       = '0;
                error_status_next   = '0;
                step.res.start_req  = REQ_SET;
            end
            KIND_STATUS:
            begin
                unique case (item.status_code)
                    ST_START_SENT:
                    begin
                        step.res.load_data = 1'b1;
                        step.res.data_out  = target_addr_reg & ADDR_WRITE_MASK;
                        step.res.clear_si  = 1'b1;
                    end
                    ST_RESTART_SENT:
                    begin
                        step.res.load_data = 1'b1;
                        step.res.data_out  = target_addr_reg | 8'h01;
                        step.res.clear_si  = 1'b1;
                    end
                    ST_ADDR_W_ACK:
                    begin
                        step.res.start_req = REQ_CLR;
                        step.res.clear_si  = 1'b1;
                        if (bytes_left_reg == '0)
                        begin
                            step.res.stop_req = 1'b1;
                            step.res.outcome  = done_outcome;
                        end
                        else
                        begin
                            step.res.load_data = 1'b1;
                            step.res.data_out  = start_register_reg;
                        end
                    end
                    ST_DATA_W_ACK:
                    begin
                        step.res.clear_si = 1'b1;
                        if (is_read)
                        begin
                            // Register sent for a read: go for a repeated start.
                            step.res.start_req = REQ_SET;
                        end
                        else if (bytes_left_reg == '0)
                        begin
                            step.res.start_req = REQ_CLR;
                            step.res.stop_req  = 1'b1;
                            step.res.outcome   = done_outcome;
                        end
                        else
                        begin
                            step.res.load_data = 1'b1;
                            step.use_mem       = 1'b1;
                            position_next      = position_inc;
                            bytes_left_next    = bytes_dec;
                        end
                    end
                    ST_ADDR_R_ACK:
                    begin
                        step.res.start_req = REQ_CLR;
                        step.res.ack_req   = (bytes_left_reg > BLW'(1)) ? REQ_SET : REQ_CLR;
                        step.res.clear_si  = 1'b1;
                    end
                    ST_DATA_R_ACK:
                    begin
                        step.res.rx_valid = 1'b1;
                        step.res.rx_byte  = item.rx_data;
                        step.res.rx_index = 8'(position_reg);
                        position_next     = position_inc;
                        bytes_left_next   = bytes_dec;
                        step.res.ack_req  = (bytes_dec == BLW'(1)) ? REQ_CLR : REQ_SET;
                        step.res.clear_si = 1'b1;
                    end
                    ST_DATA_R_NACK:
                    begin
                        step.res.rx_valid  = 1'b1;
                        step.res.rx_byte   = item.rx_data;
                        step.res.rx_index  = 8'(position_reg);
                        step.res.start_req = REQ_CLR;
                        step.res.stop_req  = 1'b1;
                        step.res.clear_si  = 1'b1;
                        step.res.outcome   = done_outcome;
                    end
                    ST_ARB_LOST:
                    begin
                        // The bus is gone: no stop, just report the failure.
                        error_status_next = item.status_code;
                        step.res.outcome  = done_outcome;
                    end
                    default:
                    begin
                        error_status_next  = item.status_code;
                        step.res.start_req = REQ_CLR;
                        step.res.stop_req  = 1'b1;
                        step.res.clear_si  = 1'b1;
                        step.res.outcome   = done_outcome;
                    end
                endcase
            end
            default:
            begin
                // Loads and the unused kind leave the transfer state alone.
            end
        endcase

        step.res.error_code = error_status_next;
    end

    // Transfer state registers, updated once per accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_addr_reg    <= '0;
            start_register_reg <= '0;
            bytes_left_reg     <= '0;
            position_reg       <= '0;
            error_status_reg   <= '0;
        end
        else if (acc)
        begin
            target_addr_reg    <= target_addr_next;
            start_register_reg <= start_register_next;
            bytes_left_reg     <= bytes_left_next;
            position_reg       <= position_next;
            error_status_reg   <= error_status_next;
        end
    end

    // The remaining count never exceeds the buffer depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        bytes_left_reg <= BLW'(MAX_LEN))
        else $error("bytes_left exceeds buffer depth");

    // The position always addresses a buffer entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        position_reg <= AW'(MAX_LEN - 1))
        else $error("position outside buffer");

    // A load transaction never moves the transfer state.
    assert property (@(posedge clk) disable iff (!rst_n)
        acc && (item.kind == KIND_LOAD) |=>
            $stable(position_reg) && $stable(bytes_left_reg) && $stable(error_status_reg))
        else $error("load transaction changed transfer state");

endmodule

`default_nettype wire

// ----- rtl/i2crts_master_seq.sv -----
// Top level of the I2C master register transfer sequencer.
`default_nettype none

// Usage
// -----
// in_ch carries load, start and status-event transactions; out_ch returns
// exactly one result transaction for each, in order, with the controller
// actions for that step (transmit byte, start/stop/ack requests, read byte
// with its index, completion outcome and captured error status).
// A result is registered in the second stage, then in the output register.
// Throughput: one transaction per cycle while out_ch is ready; transfer state
// is updated in the accept cycle and the write buffer read issued there, so
// the buffer read lands in the second stage and never stalls the input.
// Stalls: when out_ch is not ready the output register holds its result and
// the second stage holds the next one with its buffer data; in_ch.ready then
// falls until the output register drains.
// Reset: the transfer state is cleared and both stages emptied. The write
// buffer is not cleared; sending an entry that was never loaded gives an
// undefined byte.
module i2c_master_register_transfer_sequencer #(
    parameter int MAX_LEN = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    i2crts_in_if.sink     in_ch,
    i2crts_out_if.source  out_ch
);
    import i2crts_pkg::*;

    localparam int AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int BLW = $clog2(MAX_LEN + 1);

    logic          in_acc;
    logic          s1_adv;
    step_t         step;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    logic          s1_valid_reg, s1_valid_next;
    step_t         s1_step_reg;
    logic          out_valid_reg, out_valid_next;
    out_item_t     out_data_reg, out_data_next;

    // Handshake control of the two stages.
    assign s1_adv      = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || s1_adv;
    assign in_acc      = in_ch.valid && in_ch.ready;

    i2crts_ctrl #(
        .MAX_LEN (MAX_LEN),
        .AW      (AW),
        .BLW     (BLW)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .acc     (in_acc),
        .item    (in_ch.data),
        .step    (step),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr)
    );

    i2crts_wbuf #(
        .MAX_LEN (MAX_LEN),
        .AW      (AW)
    ) u_wbuf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (in_acc),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Merge the buffer byte into the result as it moves to the output.
    always_comb
    begin
        out_data_next = s1_step_reg.res;
        if (s1_step_reg.use_mem)
        begin
            out_data_next.data_out = rd_data;
        end
        s1_valid_next  = in_acc || (s1_valid_reg && !s1_adv);
        out_valid_next = s1_adv || (out_valid_reg && !out_ch.ready);
    end

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_step_reg <= step;
        end
        if (s1_adv)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    // Buffer data waiting in the second stage must not be overwritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> $stable(rd_data))
        else $error("buffer read data lost while stalled");

    // Only a transmit step may take its byte from the buffer.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_step_reg.use_mem |-> s1_step_reg.res.load_data)
        else $error("buffer byte used without a transmit");

    // Every accepted transaction lands in the second stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> s1_valid_reg)
        else $error("accepted transaction dropped");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the I2C master register transfer sequencer.
`default_nettype none

module tb;
    import i2crts_pkg::*;

    // Status codes that the sequencer treats as failures, and the spare kind.
    localparam logic [7:0] ST_ADDR_W_NACK = 8'h20;
    localparam logic [7:0] ST_DATA_W_NACK = 8'h30;
    localparam logic [7:0] ST_ADDR_R_NACK = 8'h48;
    localparam logic [7:0] ST_BUS_ERROR   = 8'h00;
    localparam logic [1:0] KIND_SPARE     = 2'd3;
    localparam int unsigned BUF_DEPTH     = 256;
    localparam int unsigned RANDOM_ITEMS  = 1700;

    logic clk;
    logic rst_n;

    i2crts_in_if  in_ch ();
    i2crts_out_if out_ch ();

    i2c_master_register_transfer_sequencer u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Shadow copy of the transfer state.
    logic [7:0] wr_buf [BUF_DEPTH];
    logic [7:0] dev_addr_q;
    logic [7:0] first_reg_q;
    logic [8:0] left_q;
    logic [7:0] pos_q;
    logic [7:0] err_q;

    in_item_t    item_backlog [$];
    out_item_t   actions_due [$];
    int unsigned n_queued;
    int unsigned faults;
    int unsigned gap_left;
    int unsigned stall_left;
    bit          in_fire;
    bit          calm;

    // Clock with a period of four time units.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog for a hung run.
    initial
    begin
        #3000000;
        $display("*** FAILED ***");
        $finish;
    end

    // Closing step of a transfer: drop START, request STOP, report completion.
    function automatic void close_transfer(inout out_item_t r);
        r.start_req = REQ_CLR;
        r.stop_req  = 1'b1;
        r.clear_si  = 1'b1;
        r.outcome   = dev_addr_q[0] ? OUTCOME_READ_DONE : OUTCOME_WRITE_DONE;
    endfunction

    // Controller actions caused by one input transaction; updates the shadow state.
    function automatic out_item_t sequencer_actions(in_item_t it);
        out_item_t r;
        r = '0;
        case (it.kind)
            KIND_LOAD:
            begin
                wr_buf[it.buf_index] = it.buf_byte;
            end
            KIND_START:
            begin
                dev_addr_q  = it.device_addr;
                first_reg_q = it.first_reg;
                left_q      = (it.length > 9'(BUF_DEPTH)) ? 9'(BUF_DEPTH) : it.length;
                pos_q       = '0;
                err_q       = '0;
                r.start_req = REQ_SET;
            end
            KIND_STATUS:
            begin
                case (it.status_code)
                    ST_START_SENT:
                    begin
                        r.load_data = 1'b1;
                        r.data_out  = dev_addr_q & ADDR_WRITE_MASK;
                        r.clear_si  = 1'b1;
                    end
                    ST_RESTART_SENT:
                    begin
                        r.load_data = 1'b1;
                        r.data_out  = dev_addr_q | 8'h01;
                        r.clear_si  = 1'b1;
                    end
                    ST_ADDR_W_ACK:
                    begin
                        r.start_req = REQ_CLR;
                        if (left_q == 9'd0)
                            close_transfer(r);
                        else
                        begin
                            r.load_data = 1'b1;
                            r.data_out  = first_reg_q;
                            r.clear_si  = 1'b1;
                        end
                    end
                    ST_DATA_W_ACK:
                    begin
                        // A read turns round with a repeated START after the register.
                        if (dev_addr_q[0])
                        begin
                            r.start_req = REQ_SET;
                            r.clear_si  = 1'b1;
                        end
                        else if (left_q == 9'd0)
                            close_transfer(r);
                        else
                        begin
                            r.load_data = 1'b1;
                            r.data_out  = wr_buf[pos_q];
                            r.clear_si  = 1'b1;
                            pos_q       = pos_q + 8'd1;
                            left_q      = left_q - 9'd1;
                        end
                    end
                    ST_ADDR_R_ACK:
                    begin
                        r.start_req = REQ_CLR;
                        r.ack_req   = (left_q > 9'd1) ? REQ_SET : REQ_CLR;
                        r.clear_si  = 1'b1;
                    end
                    ST_DATA_R_ACK:
                    begin
                        r.rx_valid = 1'b1;
                        r.rx_byte  = it.rx_data;
                        r.rx_index = pos_q;
                        pos_q      = pos_q + 8'd1;
                        if (left_q != 9'd0)
                            left_q = left_q - 9'd1;
                        r.ack_req  = (left_q == 9'd1) ? REQ_CLR : REQ_SET;
                        r.clear_si = 1'b1;
                    end
                    ST_DATA_R_NACK:
                    begin
                        r.rx_valid = 1'b1;
                        r.rx_byte  = it.rx_data;
                        r.rx_index = pos_q;
                        close_transfer(r);
                    end
                    ST_ARB_LOST:
                    begin
                        err_q     = it.status_code;
                        r.outcome = dev_addr_q[0] ? OUTCOME_READ_DONE : OUTCOME_WRITE_DONE;
                    end
                    default:
                    begin
                        err_q = it.status_code;
                        close_transfer(r);
                    end
                endcase
            end
            default: ;
        endcase
        r.error_code = err_q;
        return r;
    endfunction

    // Idle length: mostly none or short, now and then long, none in calm stretches.
    function automatic int unsigned pick_idle();
        int unsigned r;
        if ($urandom_range(0, 299) == 0)
            calm = !calm;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Item with every field random; callers then fix what matters.
    function automatic in_item_t scrambled();
        in_item_t it;
        it.kind        = 2'($urandom);
        it.buf_index   = 8'($urandom);
        it.buf_byte    = 8'($urandom);
        it.device_addr = 8'($urandom);
        it.first_reg   = 8'($urandom);
        it.length      = 9'($urandom);
        it.status_code = 8'($urandom);
        it.rx_data     = 8'($urandom);
        return it;
    endfunction

    task automatic queue_item(input in_item_t it);
        item_backlog.push_back(it);
        n_queued++;
    endtask

    task automatic queue_load(input logic [7:0] idx, input logic [7:0] val);
        in_item_t it;
        it           = scrambled();
        it.kind      = KIND_LOAD;
        it.buf_index = idx;
        it.buf_byte  = val;
        queue_item(it);
    endtask

    task automatic queue_start(input logic [7:0] addr, input logic [7:0] regno,
                               input logic [8:0] len);
        in_item_t it;
        it             = scrambled();
        it.kind        = KIND_START;
        it.device_addr = addr;
        it.first_reg   = regno;
        it.length      = len;
        queue_item(it);
    endtask

    task automatic queue_status(input logic [7:0] code);
        in_item_t it;
        it             = scrambled();
        it.kind        = KIND_STATUS;
        it.status_code = code;
        queue_item(it);
    endtask

    // Transfer lengths: mostly short, occasionally full or oversized.
    function automatic logic [8:0] pick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 9'($urandom_range(0, 6));
        else if (r < 96)
            return 9'($urandom_range(7, 40));
        else if (r < 98)
            return 9'($urandom_range(41, 255));
        else
            return 9'($urandom_range(256, 511));
    endfunction

    function automatic logic [7:0] fault_code();
        case ($urandom_range(0, 6))
            0: return ST_ADDR_W_NACK;
            1: return ST_DATA_W_NACK;
            2: return ST_ADDR_R_NACK;
            3: return ST_BUS_ERROR;
            4: return ST_ARB_LOST;
            5: return ST_DATA_R_NACK;
            default: return 8'($urandom);
        endcase
    endfunction

    // Well-formed register write, sometimes cut short by a failure code.
    task automatic queue_write_transfer(input logic [8:0] len);
        int unsigned eff, steps, abort_at, k;
        logic [7:0] addr;
        addr    = 8'($urandom);
        addr[0] = 1'b0;
        queue_start(addr, 8'($urandom), len);
        eff      = (len > 9'(BUF_DEPTH)) ? BUF_DEPTH : 32'(len);
        steps    = (eff == 0) ? 2 : eff + 3;
        abort_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, steps - 1) : steps;
        for (k = 0; k < steps; k++)
        begin
            if (k == abort_at)
            begin
                queue_status(fault_code());
                break;
            end
            if (k == 0)
                queue_status(ST_START_SENT);
            else if (k == 1)
                queue_status(ST_ADDR_W_ACK);
            else
                queue_status(ST_DATA_W_ACK);
        end
    endtask

    // Well-formed register read with a repeated START, sometimes cut short.
    task automatic queue_read_transfer(input logic [8:0] len);
        int unsigned eff, steps, abort_at, k;
        logic [7:0] addr;
        addr    = 8'($urandom);
        addr[0] = 1'b1;
        queue_start(addr, 8'($urandom), len);
        eff      = (len > 9'(BUF_DEPTH)) ? BUF_DEPTH : 32'(len);
        steps    = (eff == 0) ? 2 : eff + 5;
        abort_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, steps - 1) : steps;
        for (k = 0; k < steps; k++)
        begin
            if (k == abort_at)
            begin
                queue_status(fault_code());
                break;
            end
            case (k)
                0: queue_status(ST_START_SENT);
                1: queue_status(ST_ADDR_W_ACK);
                2: queue_status(ST_DATA_W_ACK);
                3: queue_status(ST_RESTART_SENT);
                4: queue_status(ST_ADDR_R_ACK);
                default: queue_status((k == steps - 1) ? ST_DATA_R_NACK : ST_DATA_R_ACK);
            endcase
        end
    endtask

    // Single stray transaction of any kind.
    task automatic queue_noise();
        in_item_t it;
        it = scrambled();
        case ($urandom_range(0, 3))
            0: it.kind = KIND_LOAD;
            1: it.kind = KIND_SPARE;
            2: it.kind = KIND_STATUS;
            default: it.kind = KIND_START;
        endcase
        queue_item(it);
    endtask

    task automatic check_field(input string fname, input int unsigned want,
                               input int unsigned got);
        if (want !== got)
        begin
            if (faults < 10)
                $display("mismatch in %s: expected %0h, got %0h", fname, want, got);
            faults++;
        end
    endtask

    // Input driver: a new transaction is offered only once the previous one is taken.
    always @(negedge clk)
    begin
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else if (!in_ch.valid || in_fire)
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end
            else if (item_backlog.size() != 0)
            begin
                in_ch.data  <= item_backlog.pop_front();
                in_ch.valid <= 1'b1;
                gap_left = pick_idle();
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // Result side back-pressure.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (stall_left != 0)
        begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= 1'b1;
            stall_left = pick_idle();
        end
    end

    // Monitor: check each result transaction, then predict for each accepted one.
    always @(posedge clk)
    begin : monitor
        out_item_t want;
        if (!rst_n)
            in_fire = 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (actions_due.size() == 0)
                begin
                    if (faults < 10)
                        $display("result transaction with none expected: %p", out_ch.data);
                    faults++;
                end
                else
                begin
                    want = actions_due.pop_front();
                    check_field("load_data",  want.load_data,  out_ch.data.load_data);
                    check_field("data_out",   want.data_out,   out_ch.data.data_out);
                    check_field("start_req",  want.start_req,  out_ch.data.start_req);
                    check_field("stop_req",   want.stop_req,   out_ch.data.stop_req);
                    check_field("ack_req",    want.ack_req,    out_ch.data.ack_req);
                    check_field("clear_si",   want.clear_si,   out_ch.data.clear_si);
                    check_field("rx_valid",   want.rx_valid,   out_ch.data.rx_valid);
                    check_field("rx_byte",    want.rx_byte,    out_ch.data.rx_byte);
                    check_field("rx_index",   want.rx_index,   out_ch.data.rx_index);
                    check_field("outcome",    want.outcome,    out_ch.data.outcome);
                    check_field("error_code", want.error_code, out_ch.data.error_code);
                end
            end
            in_fire = in_ch.valid && in_ch.ready;
            if (in_fire)
                actions_due.push_back(sequencer_actions(in_ch.data));
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int unsigned i, r;
        rst_n        = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        dev_addr_q   = '0;
        first_reg_q  = '0;
        left_q       = '0;
        pos_q        = '0;
        err_q        = '0;
        faults       = 0;
        gap_left     = 0;
        stall_left   = 0;
        in_fire      = 1'b0;
        calm         = 1'b0;
        n_queued     = 0;

        // Directed part: a short write using only loaded entries, a probe read,
        // an oversized read, a read that runs out of bytes, and failure codes.
        queue_load(8'h00, 8'h00);
        queue_load(8'h01, 8'hFF);
        queue_load(8'hFF, 8'hA5);
        queue_start(8'hFE, 8'hFF, 9'd2);
        queue_status(ST_START_SENT);
        queue_status(ST_ADDR_W_ACK);
        queue_status(ST_DATA_W_ACK);
        queue_status(ST_DATA_W_ACK);
        queue_status(ST_DATA_W_ACK);
        queue_start(8'h01, 8'h00, 9'd0);
        queue_status(ST_START_SENT);
        queue_status(ST_ADDR_W_ACK);
        queue_start(8'hFF, 8'h80, 9'd511);
        queue_status(ST_RESTART_SENT);
        queue_status(ST_DATA_W_ACK);
        queue_status(ST_ADDR_R_ACK);
        queue_status(ST_DATA_R_ACK);
        queue_status(ST_DATA_R_NACK);
        queue_start(8'h03, 8'h7F, 9'd1);
        queue_status(ST_ADDR_R_ACK);
        queue_status(ST_DATA_R_ACK);
        queue_status(ST_DATA_R_ACK);
        queue_status(ST_ARB_LOST);
        queue_status(ST_BUS_ERROR);
        queue_status(ST_ADDR_W_NACK);
        queue_noise();

        // Random part: fill the whole buffer first so that any write may follow,
        // then one full-length write to wrap the position.
        n_queued = 0;
        for (i = 0; i < BUF_DEPTH; i++)
            queue_load(i[7:0], 8'($urandom));
        queue_write_transfer(9'($urandom_range(256, 511)));
        while (n_queued < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                queue_write_transfer(pick_len());
            else if (r < 80)
                queue_read_transfer(pick_len());
            else
                queue_noise();
        end

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        while (item_backlog.size() != 0 || in_ch.valid)
            @(posedge clk);
        while (actions_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (faults == 0 && actions_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
